FILE: hdl/grabcut_neighbor_weights_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbor weight block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRABCUT_NEIGHBOR_WEIGHTS_TOP_MACROS_SVH
`define GRABCUT_NEIGHBOR_WEIGHTS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GNW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gnw: same-cycle check failed");
`define GNW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gnw: next-cycle check failed");
`else
`define GNW_ASSERT_IMP(lbl, ante, cons)
`define GNW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/gnw_pkg.sv
// ----------------------------------------------------------------------------
// gnw_pkg
// Shared widths, constants, types and the reciprocal table.
// ----------------------------------------------------------------------------
package gnw_pkg;

	localparam int PIX_W      = 24;
	localparam int D2_W       = 18;
	localparam int SUM_W      = 40;
	localparam int BETA_W     = 32;
	localparam int WT_W       = 16;
	localparam int MUL_W      = 32;
	localparam int DIV_N_W    = 46;
	localparam int DIV_D_W    = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIM_REG_W  = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 2'd2;

	localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 11'd480;
	localparam logic [WT_W-1:0]      GAMMA_RST  = 16'd12800;

	localparam logic [29:0] LN2_Q30    = 30'd744261118;
	localparam logic [30:0] Q30_ONE    = 31'd1073741824;
	localparam logic [16:0] GAIN_STR   = 17'd65536;
	localparam logic [16:0] GAIN_DIAG  = 17'd46341;
	localparam logic [3:0]  EXP_TERMS  = 4'd10;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_N_W-1:0] quot;
		logic [DIV_D_W-1:0] rem;
	} div_rsp_t;

	// floor((2^32-1)/k): estimate is exact or one low for p < 2^31
	function automatic logic [31:0] recip_q32(input logic [3:0] k);
		case (k)
			4'd1:    return 32'd4294967295;
			4'd2:    return 32'd2147483647;
			4'd3:    return 32'd1431655765;
			4'd4:    return 32'd1073741823;
			4'd5:    return 32'd858993459;
			4'd6:    return 32'd715827882;
			4'd7:    return 32'd613566756;
			4'd8:    return 32'd536870911;
			4'd9:    return 32'd477218588;
			default: return 32'd429496729;
		endcase
	endfunction

endpackage

FILE: hdl/gnw_if.sv
// ----------------------------------------------------------------------------
// gnw_in_if / gnw_out_if
// Valid/ready channels for pixels in and results out.
// ----------------------------------------------------------------------------
interface gnw_in_if;
	import gnw_pkg::*;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] color_c0;
	logic [7:0] color_c1;
	logic [7:0] color_c2;
	modport source (output valid, kind, color_c0, color_c1, color_c2, input ready);
	modport sink (input valid, kind, color_c0, color_c1, color_c2, output ready);
endinterface

interface gnw_out_if;
	import gnw_pkg::*;
	logic              valid;
	logic              ready;
	logic              is_beta_report;
	logic [BETA_W-1:0] beta_value;
	logic [WT_W-1:0]   weight_left;
	logic [WT_W-1:0]   weight_upleft;
	logic [WT_W-1:0]   weight_up;
	logic [WT_W-1:0]   weight_upright;
	modport source (output valid, is_beta_report, beta_value, weight_left,
		weight_upleft, weight_up, weight_upright, input ready);
	modport sink (input valid, is_beta_report, beta_value, weight_left,
		weight_upleft, weight_up, weight_upright, output ready);
endinterface

FILE: hdl/gnw_mul.sv
// ----------------------------------------------------------------------------
// gnw_mul
// Shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module gnw_mul (
	input  logic                           clk,
	input  logic [gnw_pkg::MUL_W-1:0]      a,
	input  logic [gnw_pkg::MUL_W-1:0]      b,
	output logic [2*gnw_pkg::MUL_W-1:0]    prod
);
	import gnw_pkg::*;

	logic [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

	assign prod = prod_q;
endmodule

FILE: hdl/gnw_div.sv
// ----------------------------------------------------------------------------
// gnw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gnw_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gnw_pkg::div_req_t req,
	output gnw_pkg::div_rsp_t rsp
);
	import gnw_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_N_W-1:0] quot_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dsr_q;
	logic [DIV_D_W:0]   rem_sh;
	logic [DIV_D_W:0]   rem_sub;
	logic               fits;

	assign rem_sh  = {rem_q, quot_q[DIV_N_W-1]};
	assign fits    = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_N_W-2:0], fits};
			rem_q  <= fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule

FILE: hdl/gnw_line.sv
// ----------------------------------------------------------------------------
// gnw_line
// One-row pixel store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gnw_line #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  gnw_pkg::pix_t wdata,
	input  logic [AW-1:0] raddr,
	output gnw_pkg::pix_t rdata
);
	import gnw_pkg::*;

	pix_t mem [DEPTH];
	pix_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hdl/grabcut_neighbor_weights_top.sv
// ----------------------------------------------------------------------------
// grabcut_neighbor_weights_top
// 8-neighbor smoothness weights: beta measurement and weight output.
// ----------------------------------------------------------------------------
// Pixels enter on pix_in in raster order. kind 0 (measure) accumulates the
// squared color distances to the left, up-left, up and up-right neighbors;
// the last pixel of the frame returns a beta report on res_out. kind 1
// (weight) returns one transaction with the four neighbor weights, Q8.8.
// The user must write the registers through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce this. pix_in.ready is high
// only between pixels. The last measure pixel of a frame adds the beta
// division on the divider (46 steps) unless the sum is zero. A weight pixel
// runs an exponential per present neighbor: it reduces the range by ln2 in
// five compare-and-subtract steps, then runs ten series terms of four steps
// (S_T1 to S_T4) on the shared multiplier; an exponent of 16 or more skips it.
// A result sits in an output register; when res_out stalls, the block
// holds before loading the next result. Reset clears the positions, the
// sum, beta and the registers to their defaults; the row store needs no
// clearing since the top row never reads it.
// ----------------------------------------------------------------------------
`include "grabcut_neighbor_weights_top_macros.svh"

module grabcut_neighbor_weights_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	gnw_in_if.sink                             pix_in,
	gnw_out_if.source                          res_out,
	input  logic                               cfg_we,
	input  logic [gnw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gnw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gnw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RD_UP = 5'd1;
	localparam logic [4:0] S_RD_UR = 5'd2;
	localparam logic [4:0] S_NB    = 5'd3;
	localparam logic [4:0] S_DISP  = 5'd4;
	localparam logic [4:0] S_XCHK  = 5'd5;
	localparam logic [4:0] S_NDIV  = 5'd6;
	localparam logic [4:0] S_T1    = 5'd7;
	localparam logic [4:0] S_T2    = 5'd8;
	localparam logic [4:0] S_T3    = 5'd9;
	localparam logic [4:0] S_T4    = 5'd10;
	localparam logic [4:0] S_EEND  = 5'd11;
	localparam logic [4:0] S_GAM   = 5'd12;
	localparam logic [4:0] S_GE    = 5'd13;
	localparam logic [4:0] S_GW    = 5'd14;
	localparam logic [4:0] S_NEXT  = 5'd15;
	localparam logic [4:0] S_FIN   = 5'd16;
	localparam logic [4:0] S_PAIRS = 5'd17;
	localparam logic [4:0] S_BDIV  = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;
	localparam logic [4:0] S_UPD   = 5'd20;

	logic [DIM_REG_W-1:0] width_q;
	logic [DIM_REG_W-1:0] height_q;
	logic [WT_W-1:0]      gamma_q;
	logic [WW-1:0]        eff_w;
	logic [HW-1:0]        eff_h;

	logic [4:0]        st_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	pix_t              prev_q;
	pix_t              ul_q;
	pix_t              up_q;
	pix_t              ur_q;
	pix_t              pix_q;
	logic              kind_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BETA_W-1:0] beta_q;
	logic [1:0]        nb_q;
	logic [D2_W-1:0]   d2_q;
	logic [4:0]        n_q;
	logic [33:0]       xr_q;
	logic [2:0]        sh_q;
	logic [29:0]       r_q;
	logic [30:0]       term_q;
	logic signed [32:0] acc_q;
	logic [3:0]        k_q;
	logic [29:0]       p30_q;
	logic [29:0]       q0_q;
	logic [30:0]       e_q;
	logic [WT_W-1:0]   wt_q [4];

	logic              ov_q;
	logic              o_beta_rep_q;
	logic [BETA_W-1:0] o_beta_q;
	logic [WT_W-1:0]   o_wl_q;
	logic [WT_W-1:0]   o_wul_q;
	logic [WT_W-1:0]   o_wu_q;
	logic [WT_W-1:0]   o_wur_q;

	logic              last_col;
	logic              last_row;
	logic              has_left;
	logic              has_up;
	logic              has_ur;
	logic [3:0]        pres;
	pix_t              nb_pix;
	logic [CW-1:0]     line_raddr;
	pix_t              line_rdata;

	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] prod;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               x_big;
	logic [33:0]        ln2_sh;
	logic               ln2_fits;
	logic [33:0]        xr_sub;
	logic [33:0]        remk;
	logic [30:0]        q_nx;
	logic [SUM_W:0]     sum_add;
	logic [26:0]        pairs;
	logic [2*MUL_W-1:0] wsum;

	function automatic logic [D2_W-1:0] dist2(input pix_t a, input pix_t b);
		logic [7:0]      d0;
		logic [7:0]      d1;
		logic [7:0]      d2;
		logic [D2_W-1:0] acc;
		d0 = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
		d1 = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
		d2 = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
		acc = D2_W'(d0) * D2_W'(d0) + D2_W'(d1) * D2_W'(d1) + D2_W'(d2) * D2_W'(d2);
		return acc;
	endfunction

	// clamp the size registers to 1..MAX
	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
	end

	assign last_col = (32'(col_q) + 32'd1) >= 32'(eff_w);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(eff_h);
	assign has_left = col_q != '0;
	assign has_up   = row_q != '0;
	assign has_ur   = has_up && ((32'(col_q) + 32'd1) < 32'(eff_w));
	assign pres     = {has_ur, has_up, has_left && has_up, has_left};

	always_comb begin
		case (nb_q)
			2'd0:    nb_pix = prev_q;
			2'd1:    nb_pix = ul_q;
			2'd2:    nb_pix = up_q;
			default: nb_pix = ur_q;
		endcase
	end

	assign line_raddr = (st_q == S_RD_UP) ? col_q + 1'b1 : col_q;

	gnw_line #(.DEPTH(MAX_WIDTH), .AW(CW)) u_line (
		.clk   (clk),
		.we    (st_q == S_UPD),
		.waddr (col_q),
		.wdata (pix_q),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_DISP: begin
				mul_a = beta_q;
				mul_b = MUL_W'(d2_q);
			end
			S_T1: begin
				mul_a = MUL_W'(term_q);
				mul_b = MUL_W'(r_q);
			end
			S_T2: begin
				mul_a = MUL_W'(prod[59:30]);
				mul_b = recip_q32(k_q);
			end
			S_T3: begin
				mul_a = MUL_W'(prod[61:32]);
				mul_b = MUL_W'(k_q);
			end
			S_GAM: begin
				mul_a = MUL_W'(gamma_q);
				mul_b = nb_q[0] ? MUL_W'(GAIN_DIAG) : MUL_W'(GAIN_STR);
			end
			S_GE: begin
				mul_a = prod[MUL_W-1:0];
				mul_b = MUL_W'(e_q);
			end
			S_FIN: begin
				mul_a = MUL_W'(eff_w);
				mul_b = MUL_W'(eff_h);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gnw_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign x_big = |prod[63:24];
	assign pairs = 27'({prod[24:0], 2'b00}) + 27'd2 - 27'(eff_w) * 27'd3 - 27'(eff_h) * 27'd3;

	always_comb begin
		div_req = '0;
		case (st_q)
			S_PAIRS: begin
				div_req.start    = 1'b1;
				div_req.dividend = {pairs, 19'b0};
				div_req.divisor  = sum_q;
			end
			default: div_req = '0;
		endcase
	end

	gnw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// range reduction: one compare and subtract of ln2 << sh_q per quotient bit
	assign ln2_sh   = 34'(LN2_Q30) << sh_q;
	assign ln2_fits = xr_q >= ln2_sh;
	assign xr_sub   = xr_q - ln2_sh;

	// quotient correction: the reciprocal estimate is at most one low
	assign remk    = {4'b0, p30_q} - prod[33:0];
	assign q_nx    = (remk >= 34'(k_q)) ? 31'(q0_q) + 31'd1 : 31'(q0_q);
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(d2_q);
	assign wsum    = prod + (2*MUL_W)'(64'd1 << 45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			gamma_q  <= GAMMA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[DIM_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_REG_W-1:0];
				CFG_GAMMA:  gamma_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			ov_q         <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			prev_q       <= '0;
			ul_q         <= '0;
			up_q         <= '0;
			ur_q         <= '0;
			pix_q        <= '0;
			kind_q       <= 1'b0;
			sum_q        <= '0;
			beta_q       <= '0;
			nb_q         <= '0;
			d2_q         <= '0;
			n_q          <= '0;
			xr_q         <= '0;
			sh_q         <= '0;
			r_q          <= '0;
			term_q       <= '0;
			acc_q        <= '0;
			k_q          <= '0;
			p30_q        <= '0;
			q0_q         <= '0;
			e_q          <= '0;
			wt_q         <= '{default: '0};
			o_beta_rep_q <= 1'b0;
			o_beta_q     <= '0;
			o_wl_q       <= '0;
			o_wul_q      <= '0;
			o_wu_q       <= '0;
			o_wur_q      <= '0;
		end else begin
			if (st_q == S_OUT && (!ov_q || res_out.ready)) begin
				ov_q <= 1'b1;
			end else if (ov_q && res_out.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (pix_in.valid) begin
						kind_q <= pix_in.kind;
						pix_q  <= {pix_in.color_c2, pix_in.color_c1, pix_in.color_c0};
						wt_q   <= '{default: '0};
						nb_q   <= '0;
						st_q   <= S_RD_UP;
					end
				end
				S_RD_UP: begin
					up_q <= line_rdata;
					st_q <= S_RD_UR;
				end
				S_RD_UR: begin
					ur_q <= line_rdata;
					st_q <= S_NB;
				end
				S_NB: begin
					d2_q <= dist2(pix_q, nb_pix);
					st_q <= S_DISP;
				end
				S_DISP: begin
					if (!pres[nb_q]) begin
						st_q <= S_NEXT;
					end else if (!kind_q) begin
						sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
						st_q  <= S_NEXT;
					end else begin
						st_q <= S_XCHK;
					end
				end
				S_XCHK: begin
					// exponent of 16 or more gives zero
					if (x_big) begin
						e_q  <= '0;
						st_q <= S_GAM;
					end else begin
						xr_q <= {prod[23:0], 10'b0};
						n_q  <= '0;
						sh_q <= 3'd4;
						st_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					n_q  <= {n_q[3:0], ln2_fits};
					xr_q <= ln2_fits ? xr_sub : xr_q;
					if (sh_q == 3'd0) begin
						r_q    <= ln2_fits ? xr_sub[29:0] : xr_q[29:0];
						term_q <= Q30_ONE;
						acc_q  <= $signed({2'b00, Q30_ONE});
						k_q    <= 4'd1;
						st_q   <= S_T1;
					end else begin
						sh_q <= sh_q - 3'd1;
					end
				end
				S_T1: st_q <= S_T2;
				S_T2: begin
					p30_q <= prod[59:30];
					st_q  <= S_T3;
				end
				S_T3: begin
					q0_q <= prod[61:32];
					st_q <= S_T4;
				end
				S_T4: begin
					term_q <= q_nx;
					acc_q  <= k_q[0] ? acc_q - $signed({2'b00, q_nx})
					                 : acc_q + $signed({2'b00, q_nx});
					if (k_q == EXP_TERMS) begin
						st_q <= S_EEND;
					end else begin
						k_q  <= k_q + 4'd1;
						st_q <= S_T1;
					end
				end
				S_EEND: begin
					e_q  <= acc_q[32] ? '0 : 31'(acc_q[31:0] >> n_q);
					st_q <= S_GAM;
				end
				S_GAM: st_q <= S_GE;
				S_GE:  st_q <= S_GW;
				S_GW: begin
					wt_q[nb_q] <= wsum[61:46];
					st_q       <= S_NEXT;
				end
				S_NEXT: begin
					if (nb_q == 2'd3) begin
						st_q <= S_FIN;
					end else begin
						nb_q <= nb_q + 2'd1;
						st_q <= S_NB;
					end
				end
				S_FIN: begin
					if (kind_q) begin
						st_q <= S_OUT;
					end else if (last_col && last_row) begin
						if (sum_q == '0) begin
							beta_q <= '0;
							st_q   <= S_OUT;
						end else begin
							st_q <= S_PAIRS;
						end
					end else begin
						st_q <= S_UPD;
					end
				end
				S_PAIRS: st_q <= S_BDIV;
				S_BDIV: begin
					if (div_rsp.done) begin
						beta_q <= (|div_rsp.quot[DIV_N_W-1:BETA_W]) ? '1
						                                            : div_rsp.quot[BETA_W-1:0];
						st_q   <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!ov_q || res_out.ready) begin
						o_beta_rep_q <= !kind_q;
						o_beta_q     <= beta_q;
						o_wl_q       <= wt_q[0];
						o_wul_q      <= wt_q[1];
						o_wu_q       <= wt_q[2];
						o_wur_q      <= wt_q[3];
						st_q         <= S_UPD;
					end
				end
				S_UPD: begin
					prev_q <= pix_q;
					if (last_col) begin
						ul_q  <= '0;
						col_q <= '0;
						if (last_row) begin
							row_q <= '0;
							sum_q <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						ul_q  <= up_q;
						col_q <= col_q + 1'b1;
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign pix_in.ready           = (st_q == S_IDLE);
	assign res_out.valid          = ov_q;
	assign res_out.is_beta_report = o_beta_rep_q;
	assign res_out.beta_value     = o_beta_q;
	assign res_out.weight_left    = o_wl_q;
	assign res_out.weight_upleft  = o_wul_q;
	assign res_out.weight_up      = o_wu_q;
	assign res_out.weight_upright = o_wur_q;

	`GNW_ASSERT_NXT(a_accept_reads, pix_in.valid && pix_in.ready, st_q == S_RD_UP)
	`GNW_ASSERT_NXT(a_out_stall_holds, st_q == S_OUT && ov_q && !res_out.ready, st_q == S_OUT)
	`GNW_ASSERT_NXT(a_frame_wrap, st_q == S_UPD && last_col && last_row, sum_q == '0 && col_q == '0 && row_q == '0)
	`GNW_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy)
endmodule
